@@ rtl/core/mcst_pkg.sv @@
`default_nettype none
package mcst_pkg;
    localparam int SLOT_COUNT  = 16;
    localparam int FIXED_SLOTS = 4;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int PERIOD_W    = 22;
    localparam int COUNT_W     = 16;
    localparam int CLASS_N     = 4;
    localparam int REG_IDX_W   = 2;

    localparam logic [2:0] FUNC_START   = 3'd0;
    localparam logic [2:0] FUNC_ALLOC   = 3'd1;
    localparam logic [2:0] FUNC_STOP    = 3'd2;
    localparam logic [2:0] FUNC_DESTROY = 3'd3;
    localparam logic [2:0] FUNC_TICK    = 3'd4;

    localparam logic KIND_ALLOC  = 1'b0;
    localparam logic KIND_EXPIRE = 1'b1;

    localparam logic [PERIOD_W-1:0] PERIOD_RST0 = 22'd10;
    localparam logic [PERIOD_W-1:0] PERIOD_RST1 = 22'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RST2 = 22'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST3 = 22'd3600000;

    // one slot entry as stored in memory
    typedef struct packed {
        logic                periodic;
        logic                notify;
        logic [1:0]          cls;
        logic [COUNT_W-1:0]  reload;
        logic [COUNT_W-1:0]  remaining;
    } t_slot;

    localparam int ENTRY_W = $bits(t_slot);
endpackage
`default_nettype wire

@@ rtl/core/mcst_ram.sv @@
`default_nettype none
module mcst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/mcst_prescale.sv @@
`default_nettype none
module mcst_prescale
    import mcst_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [PERIOD_W-1:0]   i_cfg_data,
    input  wire logic                  i_tick,
    output logic [CLASS_N-1:0]         o_step
);
    logic [PERIOD_W-1:0] r_period [CLASS_N];
    logic [PERIOD_W-1:0] r_count  [CLASS_N];
    logic [PERIOD_W-1:0] n_count  [CLASS_N];
    logic [CLASS_N-1:0]  r_step;
    logic [CLASS_N-1:0]  n_step;

    // increment and compare per class
    always_comb begin
        for (int c = 0; c < CLASS_N; c++) begin
            n_count[c] = r_count[c] + 1'b1;
            n_step[c]  = n_count[c] >= r_period[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period[0] <= PERIOD_RST0;
            r_period[1] <= PERIOD_RST1;
            r_period[2] <= PERIOD_RST2;
            r_period[3] <= PERIOD_RST3;
            for (int c = 0; c < CLASS_N; c++) begin
                r_count[c] <= '0;
            end
            r_step <= '0;
        end else begin
            if (i_cfg_we) begin
                r_period[i_cfg_idx] <= i_cfg_data;
            end
            if (i_tick) begin
                for (int c = 0; c < CLASS_N; c++) begin
                    r_count[c] <= n_step[c] ? '0 : n_count[c];
                end
                r_step <= n_step;
            end
        end
    end

    assign o_step = r_step;
endmodule
`default_nettype wire

@@ rtl/core/multi_class_soft_timer_table.sv @@
// Timer slot table with four prescaled timer classes. Requests are taken one at a time:
// start needs only a prepare step; stop and destroy then read, wait for and update their
// slot; allocate reads, waits for and checks each dynamic slot it inspects, lowest first.
// A millisecond tick makes one pass over all slots for each class, class 0 first, and
// every slot visit goes through the slot memory (read, wait, update, issue). Expiry words
// come out in class order, then slot order. Each expiry word is held back until the next
// one is found or the scan ends, so that the final one can carry last. The output register
// lets the next request be taken while a word waits; a scan or an allocation reply stalls
// only while a new word finds that register still full. Active flags and a written flag
// per slot live in flip-flops and the other slot fields in one RAM; an entry that was
// never written counts as one-shot when stopped. A configuration write takes priority
// over a request offered in the same cycle.
`default_nettype none
module multi_class_soft_timer_table
    import mcst_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [2:0]           i_func,
    input  wire logic [3:0]           i_timer_id,
    input  wire logic [1:0]           i_clock_class,
    input  wire logic                 i_periodic,
    input  wire logic [15:0]          i_reload_count,
    input  wire logic                 i_notify,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_kind,
    output logic [3:0]                o_slot,
    output logic                      o_full_res,
    output logic                      o_last,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [21:0]          i_cfg_data
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PRE   = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_WAIT  = 7'b0001000,
        ST_PROC  = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // captured request
    logic [2:0]         r_func;
    logic [SLOT_W-1:0]  r_id;
    logic               r_id_ok;
    t_slot              r_load;
    logic [SLOT_W-1:0]  r_idx;
    logic [1:0]         r_cls;
    logic [SLOT_COUNT-1:0] r_active;
    logic [SLOT_COUNT-1:0] r_written;
    logic [4:0]         r_nout;
    logic               r_found;
    logic [SLOT_W-1:0]  r_fslot;
    logic               r_pend;
    logic [SLOT_W-1:0]  r_pslot;

    // output register
    logic               r_ovalid;
    logic               r_okind;
    logic [3:0]         r_oslot;
    logic               r_ofull;
    logic               r_olast;

    logic [CLASS_N-1:0] w_step;
    logic               w_tick;
    logic               w_we;
    logic [SLOT_W-1:0]  w_waddr;
    t_slot              w_wdata;
    t_slot              w_rd;
    logic               w_acc;
    logic               w_ofree;
    logic               w_oload;

    assign w_acc = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_tick = w_acc && (i_func == FUNC_TICK);
    assign w_ofree = !r_ovalid || i_ready;

    mcst_prescale u_pre (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_idx  (i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_tick     (w_tick),
        .o_step     (w_step)
    );

    mcst_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rd)
    );

    // scan slot decode
    logic               w_last_idx;
    logic               w_scan_end;
    logic               w_hit;
    logic [COUNT_W-1:0] w_dec;
    logic               w_zero;
    logic               w_emit;
    logic               w_per;
    logic               w_afree;
    logic               w_afull;

    assign w_last_idx = (r_idx == SLOT_W'(SLOT_COUNT - 1));
    assign w_scan_end = w_last_idx && (r_cls == 2'd3);
    assign w_hit  = r_active[r_idx] && (w_rd.cls == r_cls) && w_step[r_cls];
    assign w_dec  = (w_rd.remaining != '0) ? w_rd.remaining - 1'b1 : '0;
    assign w_zero = (w_dec == '0);
    assign w_emit = w_hit && w_zero && w_rd.notify && (r_nout < 5'd16);
    // an entry never written holds no periodic flag yet
    assign w_per  = r_written[r_idx] && w_rd.periodic;
    assign w_afree = (FIXED_SLOTS < SLOT_COUNT) && !r_active[r_idx];
    assign w_afull = !w_afree && ((FIXED_SLOTS >= SLOT_COUNT) || w_last_idx);

    // output register load
    assign w_oload = ((r_state == ST_PROC) && (r_func == FUNC_ALLOC) &&
                      (w_afree || w_afull) && w_ofree) ||
                     ((r_state == ST_OUT) && r_found && r_pend && w_ofree) ||
                     ((r_state == ST_FIN) && r_pend && w_ofree);

    // write port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_rd;
        if (r_state == ST_PRE) begin
            w_waddr = r_id;
            w_wdata = r_load;
            w_we    = (r_func == FUNC_START) && r_id_ok && (32'(r_id) < FIXED_SLOTS);
        end else if (r_state == ST_PROC) begin
            case (r_func)
                FUNC_ALLOC: begin
                    w_wdata = r_load;
                    w_we    = w_afree && w_ofree;
                end
                FUNC_STOP: begin
                    w_wdata.remaining = w_rd.reload;
                    w_we = w_per;
                end
                FUNC_DESTROY: begin
                    w_wdata.periodic = 1'b0;
                    w_we = 1'b1;
                end
                FUNC_TICK: begin
                    w_wdata.remaining = (w_zero && w_rd.periodic) ? w_rd.reload : w_dec;
                    w_we = w_hit;
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  n_state = w_acc ? ST_PRE : ST_IDLE;
            ST_PRE: begin
                case (r_func)
                    FUNC_ALLOC, FUNC_TICK: n_state = ST_READ;
                    FUNC_STOP, FUNC_DESTROY: n_state = r_id_ok ? ST_READ : ST_IDLE;
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_READ:  n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_PROC;
            ST_PROC:  n_state = ST_OUT;
            ST_OUT:   n_state = ST_OUT;
            ST_FIN:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_active     <= '0;
            r_written    <= '0;
            r_ovalid     <= 1'b0;
            r_nout       <= '0;
            r_found      <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_ovalid <= w_oload || (r_ovalid && !i_ready);
            if (w_we) begin
                r_written[w_waddr] <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_func  <= i_func;
                        r_id    <= SLOT_W'(i_timer_id);
                        r_id_ok <= 32'(i_timer_id) < SLOT_COUNT;
                        r_load  <= '{periodic: i_periodic, notify: i_notify,
                                     cls: i_clock_class, reload: i_reload_count,
                                     remaining: i_reload_count};
                        r_nout  <= '0;
                        r_found <= 1'b0;
                        r_pend  <= 1'b0;
                        r_cls   <= 2'd0;
                        r_state <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    r_state <= n_state;
                    case (r_func)
                        FUNC_START: begin
                            if (r_id_ok && (32'(r_id) < FIXED_SLOTS)) begin
                                r_active[r_id] <= 1'b1;
                            end
                        end
                        FUNC_ALLOC: r_idx <= SLOT_W'(FIXED_SLOTS % SLOT_COUNT);
                        FUNC_TICK:  r_idx <= '0;
                        default:    r_idx <= r_id;
                    endcase
                end
                ST_READ: r_state <= ST_WAIT;
                ST_WAIT: r_state <= ST_PROC;
                ST_PROC: begin
                    case (r_func)
                        FUNC_ALLOC: begin
                            // reply waits here while the output word is still held
                            if (w_afree || w_afull) begin
                                if (w_ofree) begin
                                    r_okind <= KIND_ALLOC;
                                    r_oslot <= w_afree ? 4'(r_idx) : 4'd0;
                                    r_ofull <= w_afull;
                                    r_olast <= 1'b1;
                                    if (w_afree) begin
                                        r_active[r_idx] <= 1'b1;
                                    end
                                    r_state <= ST_IDLE;
                                end
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= ST_READ;
                            end
                        end
                        FUNC_STOP: begin
                            r_active[r_idx] <= w_per;
                            r_state <= ST_IDLE;
                        end
                        FUNC_DESTROY: begin
                            r_active[r_idx] <= 1'b0;
                            r_state <= ST_IDLE;
                        end
                        FUNC_TICK: begin
                            if (w_hit && w_zero) begin
                                r_active[r_idx] <= w_rd.periodic;
                            end
                            if (w_emit) begin
                                r_nout <= r_nout + 1'b1;
                            end
                            r_found <= w_emit;
                            r_fslot <= r_idx;
                            r_state <= ST_OUT;
                        end
                        default: r_state <= ST_IDLE;
                    endcase
                end
                ST_OUT: begin
                    // a new expiry pushes the held one out, not marked last
                    if (!(r_found && r_pend && !w_ofree)) begin
                        if (r_found) begin
                            r_pend  <= 1'b1;
                            r_pslot <= r_fslot;
                            if (r_pend) begin
                                r_okind <= KIND_EXPIRE;
                                r_oslot <= 4'(r_pslot);
                                r_ofull <= 1'b0;
                                r_olast <= 1'b0;
                            end
                        end
                        r_found <= 1'b0;
                        if (w_scan_end) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_state <= ST_READ;
                            r_idx   <= r_idx + 1'b1;
                            if (w_last_idx) begin
                                r_cls <= r_cls + 1'b1;
                            end
                        end
                    end
                end
                ST_FIN: begin
                    // held expiry word goes out last
                    if (!r_pend) begin
                        r_state <= ST_IDLE;
                    end else if (w_ofree) begin
                        r_okind <= KIND_EXPIRE;
                        r_oslot <= 4'(r_pslot);
                        r_ofull <= 1'b0;
                        r_olast <= 1'b1;
                        r_pend  <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_kind     = r_okind;
    assign o_slot     = r_oslot;
    assign o_full_res = r_ofull;
    assign o_last     = r_olast;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("output word dropped");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable({o_kind, o_slot, o_full_res, o_last}))
        else $error("output word changed while waiting");
`endif
endmodule
`default_nettype wire
